/* rtl/bdq_pkg.sv */
// Shared transaction types and codes for the button debounce event queue.
package bdq_pkg;

    typedef struct packed {
        logic        action;
        logic [7:0]  pressed_levels;
        logic [31:0] now_time;
    } in_t;

    typedef struct packed {
        logic       found;
        logic [2:0] button_index;
        logic       event_kind;
    } out_t;

    localparam logic ACT_SCAN    = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    localparam logic EV_PRESSED = 1'b0;
    localparam logic EV_LIFTED  = 1'b1;

    localparam logic CFG_DELAY  = 1'b0;
    localparam logic CFG_ACTIVE = 1'b1;

    localparam logic [15:0] DELAY_RESET  = 16'd50;
    localparam logic [3:0]  ACTIVE_RESET = 4'd8;

endpackage

/* rtl/bdq_lane.sv */
// One button lane: debounce state machine plus its own ring queue of events.
module bdq_lane #(
    parameter int QUEUE_SIZE = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        scan,
    input  logic        down,
    input  logic [31:0] now_time,
    input  logic [15:0] delay,
    input  logic        pop,
    output logic        nonempty,
    output logic        head
);

    localparam int PW = $clog2(QUEUE_SIZE);

    typedef enum logic [1:0] {
        LIFTED,
        RISING,
        PRESSED,
        FALLING
    } state_t;

    state_t          state_reg, state_next;
    logic [31:0]     start_reg, start_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [PW-1:0]   wr_reg, wr_next;
    logic            head_reg;
    logic            mem [QUEUE_SIZE];

    logic [31:0]     elapsed;
    logic            settled;
    logic            push;
    logic            push_kind;
    logic            full;
    logic            do_push;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(QUEUE_SIZE - 1))
            r = '0;
        else
            r = p + PW'(1);
        return r;
    endfunction

    assign elapsed = now_time - start_reg;
    assign settled = elapsed > {16'd0, delay};

    always_comb
    begin
        state_next = state_reg;
        start_next = start_reg;
        push       = 1'b0;
        push_kind  = bdq_pkg::EV_PRESSED;
        if (scan)
        begin
            unique case (state_reg)
                LIFTED:
                begin
                    if (down)
                    begin
                        start_next = now_time;
                        state_next = RISING;
                    end
                end
                RISING:
                begin
                    if (!down)
                        state_next = LIFTED;
                    else if (settled)
                    begin
                        state_next = PRESSED;
                        push       = 1'b1;
                        push_kind  = bdq_pkg::EV_PRESSED;
                    end
                end
                PRESSED:
                begin
                    if (!down)
                    begin
                        start_next = now_time;
                        state_next = FALLING;
                    end
                end
                FALLING:
                begin
                    if (down)
                        state_next = PRESSED;
                    else if (settled)
                    begin
                        state_next = LIFTED;
                        push       = 1'b1;
                        push_kind  = bdq_pkg::EV_LIFTED;
                    end
                end
            endcase
        end
    end

    // drop the event when the ring is full
    assign full    = (ptr_inc(wr_reg) == rd_reg);
    assign do_push = push && !full;
    assign wr_next = do_push ? ptr_inc(wr_reg) : wr_reg;
    assign rd_next = pop ? ptr_inc(rd_reg) : rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LIFTED;
            start_reg <= '0;
            rd_reg    <= '0;
            wr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
        end
    end

    // keep the head entry registered; forward a write into the slot being read
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_kind;
        if (do_push && (wr_reg == rd_next))
            head_reg <= push_kind;
        else
            head_reg <= mem[rd_next];
    end

    assign nonempty = (rd_reg != wr_reg);
    assign head     = head_reg;

endmodule

/* rtl/bdq_pick.sv */
// Merge stage: picks the lowest-numbered active lane holding an event.
module bdq_pick #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic [NUM_BUTTONS-1:0] ready_lanes,
    input  logic [NUM_BUTTONS-1:0] heads,
    output logic [NUM_BUTTONS-1:0] pick,
    output bdq_pkg::out_t          result
);

    logic [2:0] idx;

    // isolate the lowest set bit
    assign pick = ready_lanes & (~ready_lanes + NUM_BUTTONS'(1));

    always_comb
    begin
        idx = '0;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            if (pick[b])
                idx = idx | 3'(b);
        end
    end

    assign result.found        = |ready_lanes;
    assign result.button_index = idx;
    assign result.event_kind   = |(pick & heads);

endmodule

/* rtl/button_debounce_event_queue.sv */
// Top level: config registers, button lanes, pick stage and output register.
//
//  channel | signals                      | direction | moves
//  in      | in_valid  in_stall  in_data  | in        | scan or dequeue transaction
//  out     | out_valid out_stall out_data | out       | one result per dequeue
//  cfg     | cfg_write cfg_index cfg_data | in        | register write, no wait
//
// One transaction per cycle while in_stall is low: all active lanes update in the same cycle a scan is taken,
// and a dequeue picks and pops through one priority stage into the output register.
// A result appears in the cycle after its dequeue is accepted.
// in_stall is high only while a result waits in the output register and out_stall is high.
// Reset clears all lane state and pointers; queue contents are not cleared.
module button_debounce_event_queue #(
    parameter int NUM_BUTTONS = 8,
    parameter int QUEUE_SIZE  = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  bdq_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output bdq_pkg::out_t  out_data,
    input  logic           cfg_write,
    input  logic           cfg_index,
    input  logic [15:0]    cfg_data
);

    logic [15:0]            delay_reg;
    logic [3:0]             active_reg;
    logic                   out_valid_reg, out_valid_next;
    bdq_pkg::out_t          out_data_reg;

    logic                   in_acc;
    logic                   scan_acc;
    logic                   deq_acc;
    logic [NUM_BUTTONS-1:0] active_mask;
    logic [NUM_BUTTONS-1:0] nonempty;
    logic [NUM_BUTTONS-1:0] heads;
    logic [NUM_BUTTONS-1:0] pick;
    logic [NUM_BUTTONS-1:0] pop;
    bdq_pkg::out_t          pick_result;

    assign in_stall = out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;
    assign scan_acc = in_acc && (in_data.action == bdq_pkg::ACT_SCAN);
    assign deq_acc  = in_acc && (in_data.action == bdq_pkg::ACT_DEQUEUE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= bdq_pkg::DELAY_RESET;
            active_reg <= bdq_pkg::ACTIVE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bdq_pkg::CFG_DELAY:  delay_reg  <= cfg_data;
                bdq_pkg::CFG_ACTIVE: active_reg <= cfg_data[3:0];
            endcase
        end
    end

    for (genvar b = 0; b < NUM_BUTTONS; b++)
    begin : g_lane
        logic down;

        assign active_mask[b] = ({2'b00, active_reg} > 6'(b));

        if (b < 8)
        begin : g_lvl
            assign down = in_data.pressed_levels[b];
        end
        else
        begin : g_nolvl
            assign down = 1'b0;
        end

        bdq_lane #(
            .QUEUE_SIZE(QUEUE_SIZE)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .scan     (scan_acc && active_mask[b]),
            .down     (down),
            .now_time (in_data.now_time),
            .delay    (delay_reg),
            .pop      (pop[b]),
            .nonempty (nonempty[b]),
            .head     (heads[b])
        );
    end

    bdq_pick #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_pick (
        .ready_lanes (nonempty & active_mask),
        .heads       (heads),
        .pick        (pick),
        .result      (pick_result)
    );

    assign pop = pick & {NUM_BUTTONS{deq_acc}};

    // hold the result until taken, load a new one on each dequeue
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (deq_acc)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (deq_acc)
            out_data_reg <= pick_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_pop_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(pop))
        else $error("more than one lane popped");

    a_deq_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        deq_acc |=> out_valid_reg)
        else $error("dequeue produced no result");

    a_scan_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_acc && !out_valid_reg) |=> !out_valid_reg)
        else $error("scan produced a result");

    a_found_popped: assert property (@(posedge clk) disable iff (!rst_n)
        (deq_acc && (pop != '0)) |=> out_data_reg.found)
        else $error("popped event not reported");

    a_pop_only_deq: assert property (@(posedge clk) disable iff (!rst_n)
        (pop != '0) |-> deq_acc)
        else $error("pop without dequeue transaction");
`endif

endmodule
